[rtl/core/clr_pkg.sv]
// Shared types, widths and helpers for the clipped line rasterizer.
// Used by clipped_line_rasterizer_top; depends on nothing else.
`default_nettype none

package clr_pkg;

  // Coordinate and screen widths
  localparam int COORD_BITS  = 16;
  localparam int SCREEN_BITS = 12;

  // Derived widths
  localparam int DX_W  = COORD_BITS + 1;   // absolute delta
  localparam int ERR_W = COORD_BITS + 3;   // Bresenham error, signed
  localparam int DIM_W = SCREEN_BITS + 1;  // effective screen size
  localparam int CFG_W = 13;               // configuration register width
  localparam int CFG_IDX_W = 1;
  localparam int CMP_W = (COORD_BITS > DIM_W) ? COORD_BITS : DIM_W;
  localparam int EXT_W = (CFG_W > DIM_W) ? CFG_W : DIM_W;

  localparam logic [DIM_W-1:0] SCREEN_LIM = DIM_W'(1) << SCREEN_BITS;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

  // Request codes
  typedef enum logic [0:0] {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    op_t                           operation;
    logic signed [COORD_BITS-1:0]  start_x;
    logic signed [COORD_BITS-1:0]  start_y;
    logic signed [COORD_BITS-1:0]  end_x_in;
    logic signed [COORD_BITS-1:0]  end_y_in;
  } in_item_t;

  typedef struct packed {
    logic                    pixel_valid;
    logic [SCREEN_BITS-1:0]  pixel_x;
    logic [SCREEN_BITS-1:0]  pixel_y;
    logic                    line_done;
    logic                    any_visible;
    logic [SCREEN_BITS-1:0]  first_vis_x;
    logic [SCREEN_BITS-1:0]  first_vis_y;
    logic [SCREEN_BITS-1:0]  last_vis_x;
    logic [SCREEN_BITS-1:0]  last_vis_y;
  } out_item_t;

  typedef struct packed {
    logic [SCREEN_BITS-1:0] x;
    logic [SCREEN_BITS-1:0] y;
  } point_t;

  // Clamp a screen size register to the addressable range
  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] r);
    logic [DIM_W-1:0] res;
    if (EXT_W'(r) > EXT_W'(SCREEN_LIM)) begin
      res = SCREEN_LIM;
    end else begin
      res = DIM_W'(r);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/core/clipped_line_rasterizer_top.sv]
// Clipped Bresenham line generator: start requests load a line, tick requests
// step a busy line and return one result each; idle ticks are dropped. Depends on clr_pkg.
//
//  channel | signals                         | direction | payload
//  --------+---------------------------------+-----------+-------------------
//  in      | in_valid / in_ready / in_data   | into      | in_item_t
//  out     | out_valid / out_ready / out_data| out of    | out_item_t
//  cfg     | cfg_we / cfg_index / cfg_data   | into      | screen size regs
//
// One request per cycle unless a result waits in the output register; a tick's
// result appears there the cycle after it is accepted. All stepping is one pass
// of logic between the line state registers and the output register.
// Reset is synchronous; it idles the generator and restores a 640 x 480 screen.
// in_ready drops during reset and while a result sits unaccepted in the output
// register.
`default_nettype none

module clipped_line_rasterizer_top import clr_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data
);

  // Configuration registers
  logic [CFG_W-1:0] screen_width;
  logic [CFG_W-1:0] screen_height;

  // Line state
  logic signed [COORD_BITS-1:0] cur_x, cur_y, target_x, target_y;
  logic                         dir_x_neg, dir_y_neg;
  logic [DX_W-1:0]              abs_dx, abs_dy;
  logic signed [ERR_W-1:0]      error_term;
  logic                         started;
  logic                         busy;
  point_t                       first_point, last_point;

  // Combinational signals
  logic                         in_fire;
  logic                         is_start;
  logic                         tick_live;
  logic signed [DX_W-1:0]       diff_x, diff_y;
  logic [DX_W-1:0]              init_dx, init_dy;
  logic signed [ERR_W-1:0]      init_err;
  logic [DIM_W-1:0]             dim_w, dim_h;
  logic                         on_screen;
  logic                         done_now;
  logic                         step_x, step_y;
  logic signed [ERR_W-1:0]      dx_e, dy_e;
  logic signed [ERR_W-1:0]      error_next;
  logic signed [COORD_BITS-1:0] cur_x_next, cur_y_next;
  point_t                       cur_point;
  point_t                       first_next, last_next;
  logic                         started_next;
  out_item_t                    result_next;

  assign in_ready  = (!out_valid || out_ready) && !rst;
  assign in_fire   = in_valid && in_ready;
  assign is_start  = (in_data.operation == OP_START);
  assign tick_live = in_fire && !is_start && busy;

  // Prepare deltas, directions and initial error for a start request
  always_comb begin
    diff_x  = DX_W'(in_data.end_x_in) - DX_W'(in_data.start_x);
    diff_y  = DX_W'(in_data.end_y_in) - DX_W'(in_data.start_y);
    init_dx = diff_x[DX_W-1] ? DX_W'(-diff_x) : DX_W'(diff_x);
    init_dy = diff_y[DX_W-1] ? DX_W'(-diff_y) : DX_W'(diff_y);
    if (init_dx > init_dy) begin
      init_err = signed'(ERR_W'(init_dx >> 1));
    end else begin
      init_err = -signed'(ERR_W'(init_dy >> 1));
    end
  end

  // Clip test, finish test and one Bresenham step
  always_comb begin
    dim_w  = eff_dim(screen_width);
    dim_h  = eff_dim(screen_height);
    on_screen = !cur_x[COORD_BITS-1] && !cur_y[COORD_BITS-1] &&
                (CMP_W'(unsigned'(cur_x)) < CMP_W'(dim_w)) &&
                (CMP_W'(unsigned'(cur_y)) < CMP_W'(dim_h));

    cur_point.x = cur_x[SCREEN_BITS-1:0];
    cur_point.y = cur_y[SCREEN_BITS-1:0];

    started_next = started || on_screen;
    first_next   = (started || !on_screen) ? first_point : cur_point;
    last_next    = on_screen ? cur_point : last_point;

    done_now = (!on_screen && started) || (cur_x == target_x && cur_y == target_y);

    dx_e   = signed'(ERR_W'(abs_dx));
    dy_e   = signed'(ERR_W'(abs_dy));
    step_x = (error_term > -dx_e);
    step_y = (error_term < dy_e);
    error_next = error_term - (step_x ? dy_e : ERR_W'(0)) + (step_y ? dx_e : ERR_W'(0));
    cur_x_next = step_x ? (dir_x_neg ? cur_x - COORD_BITS'(1) : cur_x + COORD_BITS'(1))
                        : cur_x;
    cur_y_next = step_y ? (dir_y_neg ? cur_y - COORD_BITS'(1) : cur_y + COORD_BITS'(1))
                        : cur_y;

    result_next             = '0;
    result_next.pixel_valid = on_screen;
    if (on_screen) begin
      result_next.pixel_x = cur_point.x;
      result_next.pixel_y = cur_point.y;
    end
    result_next.line_done = done_now;
    if (done_now && started_next) begin
      result_next.any_visible = 1'b1;
      result_next.first_vis_x = first_next.x;
      result_next.first_vis_y = first_next.y;
      result_next.last_vis_x  = last_next.x;
      result_next.last_vis_y  = last_next.y;
    end
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= WIDTH_RESET;
      screen_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Load a new line on start, advance it on tick
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      started <= 1'b0;
    end else if (in_fire && is_start) begin
      cur_x       <= in_data.start_x;
      cur_y       <= in_data.start_y;
      target_x    <= in_data.end_x_in;
      target_y    <= in_data.end_y_in;
      dir_x_neg   <= diff_x[DX_W-1] || (diff_x == '0);
      dir_y_neg   <= diff_y[DX_W-1] || (diff_y == '0);
      abs_dx      <= init_dx;
      abs_dy      <= init_dy;
      error_term  <= init_err;
      started     <= 1'b0;
      busy        <= 1'b1;
      first_point <= '0;
      last_point  <= '0;
    end else if (tick_live) begin
      started     <= started_next;
      first_point <= first_next;
      last_point  <= last_next;
      if (done_now) begin
        busy <= 1'b0;
      end else begin
        cur_x      <= cur_x_next;
        cur_y      <= cur_y_next;
        error_term <= error_next;
      end
    end
  end

  // Hold the result until the consumer takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tick_live) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_live) begin
      out_data <= result_next;
    end
  end

`ifndef NO_ASSERTIONS
  // A start request always leaves the generator busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (in_fire && is_start) |=> busy)
    else $error("start request did not arm the generator");

  // A finishing tick idles the generator
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (tick_live && done_now) |=> !busy)
    else $error("generator still busy after line finished");

  // A result that plots nothing carries zero coordinates
  a_pix_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.pixel_valid) |->
      (out_data.pixel_x == '0 && out_data.pixel_y == '0))
    else $error("non-plotting result carries coordinates");

  // Visibility summary only accompanies a finished line
  a_vis_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.line_done) |-> !out_data.any_visible)
    else $error("visibility reported before line finished");
`endif

endmodule

`default_nettype wire

[tb/clipped_line_rasterizer_top_tb.sv]
// Self-checking testbench for clipped_line_rasterizer_top: drives start and tick requests,
// predicts every pixel and line-done result, and checks the output stream field by field.
// Depends on clr_pkg and the clipped_line_rasterizer_top RTL.

module clipped_line_rasterizer_top_tb;
  import clr_pkg::*;

  localparam int STALL_LIMIT = 3000;   // cycles with no handshake before giving up
  localparam int HOLD_CYCLES = 300;    // long receiver hold-off
  localparam int ITEMS_PER_SETTING = 180;
  localparam int SETTLE_CYCLES = 4;

  // Line predictor and result checker
  class raster_checker;
    logic [CFG_W-1:0]             width_reg = WIDTH_RESET;
    logic [CFG_W-1:0]             height_reg = HEIGHT_RESET;
    logic signed [COORD_BITS-1:0] cur_x, cur_y, tgt_x, tgt_y;
    logic                         neg_x, neg_y;
    logic [DX_W-1:0]              abs_dx, abs_dy;
    logic signed [ERR_W-1:0]      error_term;
    logic                         line_seen;
    logic                         line_active;
    point_t                       first_pt, last_pt;
    out_item_t                    predicted_steps[$];
    int                           errors;

    function void reset();
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      cur_x = '0; cur_y = '0; tgt_x = '0; tgt_y = '0;
      neg_x = 1'b0; neg_y = 1'b0;
      abs_dx = '0; abs_dy = '0;
      error_term = '0;
      line_seen = 1'b0;
      line_active = 1'b0;
      first_pt = '0; last_pt = '0;
      predicted_steps.delete();
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
      if (idx == REG_SCREEN_WIDTH) begin
        width_reg = val;
      end else begin
        height_reg = val;
      end
    endfunction

    // Clamp a size register to what the screen coordinates can address
    function int visible_extent(logic [CFG_W-1:0] r);
      int lim;
      lim = 1 << SCREEN_BITS;
      return (int'(r) > lim) ? lim : int'(r);
    endfunction

    function void note_request(in_item_t req);
      int        w, h, e2, adx, ady, err;
      bit        on_screen, finish;
      point_t    pt;
      out_item_t res;
      // Load a new line, abandoning any line in progress
      if (req.operation == OP_START) begin
        cur_x = req.start_x;
        cur_y = req.start_y;
        tgt_x = req.end_x_in;
        tgt_y = req.end_y_in;
        neg_x = !(cur_x < tgt_x);
        neg_y = !(cur_y < tgt_y);
        adx = int'(tgt_x) - int'(cur_x);
        ady = int'(tgt_y) - int'(cur_y);
        if (adx < 0) adx = -adx;
        if (ady < 0) ady = -ady;
        abs_dx = adx[DX_W-1:0];
        abs_dy = ady[DX_W-1:0];
        err = (adx > ady) ? adx / 2 : -ady / 2;
        error_term = err[ERR_W-1:0];
        line_seen = 1'b0;
        line_active = 1'b1;
        first_pt = '0;
        last_pt = '0;
        return;
      end
      // Drop ticks while idle
      if (!line_active) return;
      res = '0;
      finish = 1'b0;
      w = visible_extent(width_reg);
      h = visible_extent(height_reg);
      on_screen = (int'(cur_x) >= 0) && (int'(cur_y) >= 0) &&
                  (int'(cur_x) < w) && (int'(cur_y) < h);
      if (on_screen) begin
        pt.x = cur_x[SCREEN_BITS-1:0];
        pt.y = cur_y[SCREEN_BITS-1:0];
        if (!line_seen) begin
          first_pt = pt;
          line_seen = 1'b1;
        end
        last_pt = pt;
        res.pixel_valid = 1'b1;
        res.pixel_x = pt.x;
        res.pixel_y = pt.y;
      end else if (line_seen) begin
        finish = 1'b1;
      end
      if (!finish && cur_x == tgt_x && cur_y == tgt_y) finish = 1'b1;
      if (!finish) begin
        // One Bresenham step; both tests use the error from before the step
        e2 = int'(error_term);
        adx = int'(abs_dx);
        ady = int'(abs_dy);
        err = e2;
        if (e2 > -adx) begin
          err = err - ady;
          cur_x = neg_x ? COORD_BITS'(cur_x - 1) : COORD_BITS'(cur_x + 1);
        end
        if (e2 < ady) begin
          err = err + adx;
          cur_y = neg_y ? COORD_BITS'(cur_y - 1) : COORD_BITS'(cur_y + 1);
        end
        error_term = err[ERR_W-1:0];
      end else begin
        line_active = 1'b0;
        res.line_done = 1'b1;
        if (line_seen) begin
          res.any_visible = 1'b1;
          res.first_vis_x = first_pt.x;
          res.first_vis_y = first_pt.y;
          res.last_vis_x = last_pt.x;
          res.last_vis_y = last_pt.y;
        end
      end
      predicted_steps.push_back(res);
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (predicted_steps.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, got);
        errors++;
        return;
      end
      want = predicted_steps.pop_front();
      check_field("pixel_valid", want.pixel_valid, got.pixel_valid);
      check_field("pixel_x", want.pixel_x, got.pixel_x);
      check_field("pixel_y", want.pixel_y, got.pixel_y);
      check_field("line_done", want.line_done, got.line_done);
      check_field("any_visible", want.any_visible, got.any_visible);
      check_field("first_vis_x", want.first_vis_x, got.first_vis_x);
      check_field("first_vis_y", want.first_vis_y, got.first_vis_y);
      check_field("last_vis_x", want.last_vis_x, got.last_vis_x);
      check_field("last_vis_y", want.last_vis_y, got.last_vis_y);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  raster_checker sb;
  int send_idle_pct = 11;
  int recv_idle_pct = 47;
  int hold_requests = 0;
  int hold_served = 0;
  int useful_items = 0;

  clipped_line_rasterizer_top DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Check every accepted result
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  // Stall the receiver at random; serve long hold-offs on request
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // End the run when nothing moves for too long
  initial begin : watchdog
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("Mismatches found");
    $finish;
  end

  function automatic in_item_t make_start(int sx, int sy, int ex, int ey);
    in_item_t r;
    r.operation = OP_START;
    r.start_x = COORD_BITS'(sx);
    r.start_y = COORD_BITS'(sy);
    r.end_x_in = COORD_BITS'(ex);
    r.end_y_in = COORD_BITS'(ey);
    return r;
  endfunction

  // Ticks carry random, ignored coordinates
  function automatic in_item_t make_tick();
    in_item_t r;
    r = make_start($urandom, $urandom, $urandom, $urandom);
    r.operation = OP_TICK;
    return r;
  endfunction

  function automatic int near_edge(int dim);
    case ($urandom_range(2))
      0: return int'($urandom_range(12)) - 6;
      1: return dim + int'($urandom_range(12)) - 6;
      default: return int'($urandom_range(dim + 16)) - 8;
    endcase
  endfunction

  function automatic int near_limit();
    return $urandom_range(1) ? 32767 - int'($urandom_range(10))
                             : -32768 + int'($urandom_range(10));
  endfunction

  // Offer one request, optionally after a gap, and hold it until accepted
  task automatic send_request(input in_item_t req);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    if (req.operation == OP_START || sb.line_active) useful_items++;
    sb.note_request(req);
  endtask

  // Start a line and tick it until it finishes or the tick budget runs out
  task automatic run_line(input int sx, sy, ex, ey, input int max_ticks);
    int n;
    n = 0;
    send_request(make_start(sx, sy, ex, ey));
    while (sb.line_active && n < max_ticks) begin
      send_request(make_tick());
      n++;
    end
  endtask

  // Stop offering and wait until every predicted result has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.predicted_steps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_screen(input int w, input int h);
    cfg_we <= 1'b1;
    cfg_index <= REG_SCREEN_WIDTH;
    cfg_data <= CFG_W'(w);
    @(posedge clk);
    sb.set_reg(REG_SCREEN_WIDTH, CFG_W'(w));
    cfg_index <= REG_SCREEN_HEIGHT;
    cfg_data <= CFG_W'(h);
    @(posedge clk);
    sb.set_reg(REG_SCREEN_HEIGHT, CFG_W'(h));
    cfg_we <= 1'b0;
  endtask

  // Mostly complete lines near the screen edges, some abandoned, some noise
  task automatic random_line();
    int kind, w, h, sx, sy, ex, ey, reach, cap;
    kind = $urandom_range(99);
    w = sb.visible_extent(sb.width_reg);
    h = sb.visible_extent(sb.height_reg);
    reach = ($urandom_range(9) == 0) ? 120 : 20;
    sx = near_edge(w);
    sy = near_edge(h);
    ex = sx + int'($urandom_range(2 * reach)) - reach;
    ey = sy + int'($urandom_range(2 * reach)) - reach;
    if (kind < 65) begin
      cap = 400;
    end else if (kind < 80) begin
      cap = $urandom_range(4);
    end else if (kind < 92) begin
      sx = $urandom; sy = $urandom; ex = $urandom; ey = $urandom;
      cap = $urandom_range(6);
    end else begin
      sx = near_limit();
      sy = near_limit();
      ex = (sx > 0) ? sx - int'($urandom_range(10)) : sx + int'($urandom_range(10));
      ey = (sy > 0) ? sy - int'($urandom_range(10)) : sy + int'($urandom_range(10));
      cap = 40;
    end
    run_line(sx, sy, ex, ey, cap);
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 2)) send_request(make_tick());
    end
  endtask

  initial begin : stimulus
    int screen_w[9] = '{1, 16, 4096, 0, 8191, 1, 37, 4095, 640};
    int screen_h[9] = '{1, 12, 4096, 0, 8191, 37, 1, 3, 480};
    int goal;
    sb = new();
    sb.reset();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed lines on the reset screen
    send_request(make_tick());                       // tick while idle
    run_line(0, 0, 0, 0, 4);                         // degenerate line at the corner
    run_line(-3, -2, 2, 1, 10);                      // enters the screen from outside
    run_line(637, 5, 645, 9, 12);                    // leaves through the right edge
    run_line(-32768, 32767, 32767, -32768, 2);       // extreme endpoints, abandoned
    run_line(10, 10, 8, 13, 8);                      // steep, negative x
    drain();

    // Random lines over several screen sizes and idling schemes
    for (int p = 0; p < 9; p++) begin
      if (p == 3) begin
        send_idle_pct = 47;
        recv_idle_pct = 11;
      end else if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_screen(screen_w[p], screen_h[p]);
      if (p == 0 || p == 6) hold_requests++;
      goal = useful_items + ITEMS_PER_SETTING;
      while (useful_items < goal) random_line();
      drain();
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.predicted_steps.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
